[src/asid_pkg.sv]
// Package for the ADC scan and IR distance unit.
// Holds the job type passed from the front end to the back end and the fixed
// constants of the distance curve. Depends on nothing.
package asid_pkg;

    // Field widths of the stream items.
    localparam int SAMPLE_W   = 10;
    localparam int CHAN_W     = 3;
    localparam int DIST_W     = 9;
    localparam int DENOM_W    = 16;
    localparam int REM_W      = 27;
    localparam int DIVISOR_W  = 23;
    localparam int QUO_W      = 9;
    localparam int SHIFTED_W  = DIVISOR_W + QUO_W - 1;

    // Distance curve: D = 100*h + 1832, dist = (87628800 - 1206*D) / (100*D).
    localparam logic [DENOM_W-1:0]   CURVE_SCALE  = 16'd100;
    localparam logic [DENOM_W-1:0]   CURVE_OFFSET = 16'd1832;
    localparam logic [REM_W-1:0]     CURVE_NUM    = 27'd87628800;
    localparam logic [REM_W-1:0]     CURVE_BIAS   = 27'd1206;
    localparam logic [DIVISOR_W-1:0] CURVE_DIV    = 23'd100;

    // Reset value of the distance clamp register.
    localparam logic [DIST_W-1:0] LIMIT_RESET = 9'd150;

    // Depth of the job queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified item waiting for the back end.
    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [CHAN_W-1:0]   next_channel;
        logic [SAMPLE_W-1:0] sample;
        logic                dist_en;
        logic [DENOM_W-1:0]  denom_base;
    } asid_job_t;

endpackage

[src/asid_front.sv]
// Front end of the ADC scan unit: accepts samples, tags the scan channel,
// advances the round-robin index and forms the curve denominator.
// Depends on asid_pkg.
module asid_front
    import asid_pkg::*;
#(
    parameter int NUM_CHANNELS  = 6,
    parameter int FIRST_CHANNEL = 0,
    parameter int DIST_CHANNELS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] in_sample,
    output logic                job_valid,
    input  logic                job_ready,
    output asid_job_t           job
);

    logic [CHAN_W-1:0]  scan_index_reg;
    logic [CHAN_W-1:0]  scan_index_next;
    logic [CHAN_W:0]    index_inc;
    logic [QUO_W-1:0]   half_sample;
    logic               accept;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign accept    = in_valid && job_ready;

    // Round-robin step, wrapping at the last channel or from any index out of range.
    always_comb
    begin
        index_inc = {1'b0, scan_index_reg} + {{CHAN_W{1'b0}}, 1'b1};
        if (index_inc >= (CHAN_W + 1)'(NUM_CHANNELS))
        begin
            scan_index_next = '0;
        end
        else
        begin
            scan_index_next = index_inc[CHAN_W-1:0];
        end
    end

    // Classify the item and form D = 100*h + 1832 for the back end.
    always_comb
    begin
        half_sample      = in_sample[SAMPLE_W-1:1];
        job.channel      = scan_index_reg;
        job.next_channel = CHAN_W'(FIRST_CHANNEL) + scan_index_next;
        job.sample       = in_sample;
        job.dist_en      = ({1'b0, scan_index_reg} < (CHAN_W + 1)'(DIST_CHANNELS));
        job.denom_base   = CURVE_OFFSET + CURVE_SCALE * DENOM_W'(half_sample);
    end

    // Scan index register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_index_reg <= '0;
        end
        else if (accept)
        begin
            scan_index_reg <= scan_index_next;
        end
    end

endmodule

[src/asid_queue.sv]
// Short job queue between the front and the back end of the ADC scan unit.
// A small register FIFO of QUEUE_DEPTH entries. Depends on asid_pkg.
module asid_queue
    import asid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  asid_job_t push_job,
    output logic      pop_valid,
    input  logic      pop_ready,
    output asid_job_t pop_job
);

    asid_job_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count; the depth is a power of two, so pointers wrap freely.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= QCNT_W'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= QCNT_W'(count_reg - 1'b1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[src/asid_back.sv]
// Back end of the ADC scan unit: evaluates the distance curve with a
// restoring divider, one quotient bit per cycle, clamps it and holds the
// result in an output register. Depends on asid_pkg.
module asid_back
    import asid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  asid_job_t         job,
    input  logic [DIST_W-1:0] distance_limit,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAN_W-1:0]   out_channel,
    output logic [CHAN_W-1:0]   out_next_channel,
    output logic [SAMPLE_W-1:0] out_sample,
    output logic [DIST_W-1:0]   out_distance,
    output logic                out_distance_valid
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam int CNT_W = $clog2(QUO_W);

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    asid_job_t            job_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;
    logic [SHIFTED_W-1:0] dsh_reg;
    logic [SHIFTED_W-1:0] dsh_next;
    logic [QUO_W-1:0]     quo_reg;
    logic [QUO_W-1:0]     quo_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [SHIFTED_W-1:0] rem_wide;
    logic [SHIFTED_W-1:0] diff;
    logic                 fits;
    logic                 load_out;
    logic [DIST_W-1:0]    clamped;

    assign job_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // One restoring step: compare the remainder with the shifted divisor.
    always_comb
    begin
        rem_wide = SHIFTED_W'(rem_reg);
        diff     = rem_wide - dsh_reg;
        fits     = (rem_wide >= dsh_reg);
    end

    // Clamp the quotient to the limit; non-distance channels report zero.
    always_comb
    begin
        if (!job_reg.dist_en)
        begin
            clamped = '0;
        end
        else if (quo_reg > distance_limit)
        begin
            clamped = distance_limit;
        end
        else
        begin
            clamped = quo_reg;
        end
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                quo_next = '0;
                if (job_valid)
                begin
                    state_next = job.dist_en ? ST_SETUP : ST_DONE;
                end
            end
            ST_SETUP:
            begin
                rem_next = CURVE_NUM - CURVE_BIAS * REM_W'(job_reg.denom_base);
                dsh_next = {CURVE_DIV * DIVISOR_W'(job_reg.denom_base), {(QUO_W-1){1'b0}}};
                cnt_next = CNT_W'(QUO_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (fits)
                begin
                    rem_next = diff[REM_W-1:0];
                end
                quo_next = {quo_reg[QUO_W-2:0], fits};
                dsh_next = dsh_reg >> 1;
                cnt_next = CNT_W'(cnt_reg - 1'b1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output handshake register.
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and result payload.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (job_valid && job_ready)
        begin
            job_reg <= job;
        end
        if (load_out)
        begin
            out_channel        <= job_reg.channel;
            out_next_channel   <= job_reg.next_channel;
            out_sample         <= job_reg.sample;
            out_distance       <= clamped;
            out_distance_valid <= job_reg.dist_en;
        end
    end

endmodule

[src/adc_scan_ir_distance_unit.sv]
// ADC round-robin scan with IR distance linearization, top level.
// Instantiates asid_front, asid_queue and asid_back; depends on asid_pkg.
//
// Each 10-bit conversion result is tagged with its scan channel, the scan
// index steps round-robin over NUM_CHANNELS and the next multiplexer channel
// (FIRST_CHANNEL plus the new index, modulo 8) is reported. On the first
// DIST_CHANNELS channels the sample is turned into a distance,
// (87628800 - 1206*D) / (100*D) with D = 100*floor(sample/2) + 1832, clamped
// to the distance limit register (reset 150). The front end takes a sample
// whenever the two-entry job queue has room. The back end handles one item
// at a time: a distance item is taken as a job, has its operands formed,
// passes the bit-serial divider for a nine-bit quotient and is loaded into
// the output register; a non-distance item skips the operand and divider
// steps, so the divider sets the sustained rate. The limit register may
// only be written while no item is in flight; cfg_ready is always high.
module adc_scan_ir_distance_unit
    import asid_pkg::*;
#(
    parameter int NUM_CHANNELS  = 6,
    parameter int FIRST_CHANNEL = 0,
    parameter int DIST_CHANNELS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] raw_sample, [15:10] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [2:0] channel, [5:3] next_channel,
                                   // [15:6] sample_echo, [24:16] distance, [31:25] zero
    output logic [0:0]  m_tuser,   // [0] distance_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data   // distance_limit
);

    logic [DIST_W-1:0]   distance_limit_reg;
    logic                push_valid;
    logic                push_ready;
    asid_job_t           push_job;
    logic                pop_valid;
    logic                pop_ready;
    asid_job_t           pop_job;
    logic [CHAN_W-1:0]   res_channel;
    logic [CHAN_W-1:0]   res_next_channel;
    logic [SAMPLE_W-1:0] res_sample;
    logic [DIST_W-1:0]   res_distance;
    logic                res_distance_valid;

    // Distance limit register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            distance_limit_reg <= cfg_data;
        end
    end

    // Front end: tags and classifies incoming items.
    asid_front #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .FIRST_CHANNEL (FIRST_CHANNEL),
        .DIST_CHANNELS (DIST_CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[SAMPLE_W-1:0]),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    // Job queue between the two halves.
    asid_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Back end: divider, clamp and output register.
    asid_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .job_valid          (pop_valid),
        .job_ready          (pop_ready),
        .job                (pop_job),
        .distance_limit     (distance_limit_reg),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_channel        (res_channel),
        .out_next_channel   (res_next_channel),
        .out_sample         (res_sample),
        .out_distance       (res_distance),
        .out_distance_valid (res_distance_valid)
    );

    // Pack the result item.
    assign m_tdata = {7'd0, res_distance, res_sample, res_next_channel, res_channel};
    assign m_tuser = res_distance_valid;

endmodule
